// ===== design/srh_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and codes of the substring rolling hash block.
package srh_pkg;

   localparam int HASH_W   = 61;
   localparam int PROD_W   = 2 * HASH_W;
   localparam int PART_W   = 32;
   localparam int POS_W    = 12;
   localparam int KIND_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;

   localparam int unsigned DEFAULT_MAX_LEN = 4095;

   localparam logic [HASH_W-1:0] HASH_MOD  = {HASH_W{1'b1}};
   localparam logic [HASH_W-1:0] HASH_BASE = HASH_W'(100000007);

   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL
   } srh_state_type;

endpackage

// ===== design/srh_mod_mul.sv =====
`timescale 1ns / 1ps
// Multi-cycle 61 by 61 bit multiplier modulo 2^61-1 built from 32 bit partial products.
module srh_mod_mul (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [srh_pkg::HASH_W-1:0] a,
   input  logic [srh_pkg::HASH_W-1:0] b,
   output logic                      done,
   output logic [srh_pkg::HASH_W-1:0] result
);
   import srh_pkg::*;

   localparam int HI_W = HASH_W - PART_W;

   logic                  active_ff, active_in;
   logic [2:0]            cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [HASH_W-1:0]     a_ff, b_ff;
   logic [2*PART_W-1:0]   pp_ff;
   logic [1:0]            pp_idx_ff;
   logic [PROD_W-1:0]     acc_ff;
   logic [HASH_W:0]       t_ff;
   logic [HASH_W-1:0]     result_ff;

   logic [PART_W-1:0]     x_part, y_part;
   logic [PROD_W-1:0]     pp_shifted;

   // Partial product k: bit 1 picks the high half of a, bit 0 that of b.
   always_comb begin
      x_part = cnt_ff[1] ? {{(PART_W-HI_W){1'b0}}, a_ff[HASH_W-1:PART_W]} : a_ff[PART_W-1:0];
      y_part = cnt_ff[0] ? {{(PART_W-HI_W){1'b0}}, b_ff[HASH_W-1:PART_W]} : b_ff[PART_W-1:0];
   end

   always_comb begin
      case (pp_idx_ff)
         2'd0:    pp_shifted = PROD_W'(pp_ff);
         2'd1,
         2'd2:    pp_shifted = PROD_W'({pp_ff, {PART_W{1'b0}}});
         2'd3:    pp_shifted = PROD_W'({pp_ff, {(2*PART_W){1'b0}}});
         default: pp_shifted = '0;
      endcase
   end

   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = '0;
      end else if (active_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd6) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (active_ff) begin
         if (cnt_ff < 3'd4) begin
            pp_ff     <= x_part * y_part;
            pp_idx_ff <= cnt_ff[1:0];
         end
         if (cnt_ff inside {[3'd1:3'd4]}) begin
            acc_ff <= acc_ff + pp_shifted;
         end
         if (cnt_ff == 3'd5) begin
            t_ff <= {1'b0, acc_ff[PROD_W-1:HASH_W]} + {1'b0, acc_ff[HASH_W-1:0]};
         end
         if (cnt_ff == 3'd6) begin
            result_ff <= (t_ff >= {1'b0, HASH_MOD}) ? HASH_W'(t_ff - {1'b0, HASH_MOD})
                                                      : t_ff[HASH_W-1:0];
         end
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== design/substring_rolling_hash.sv =====
`timescale 1ns / 1ps
// Top level of the substring rolling hash block: prefix hash and power stores and the sequencer.
//
// Usage. A command beat is taken at a rising edge where start is high and busy is low.
// req_kind selects append (req_char_byte), query (req_left, req_right) or clear.
// Every command gives exactly one result beat: rsp_valid is high for one cycle with
// rsp_hash_value and rsp_status; the receiver cannot stall, so it must take the beat.
// Sequencing. Clear, the unused kind, a dropped append on a full store and a query with
// a bad range answer in the cycle after acceptance, and a new command may follow in the
// very next cycle. A good append or query first does the synchronous store read and then
// the modular multiply, with busy high until the result beat. The multiply issues one
// 32 by 32 bit partial product per cycle, adds them up and folds the product modulo
// 2^61-1. The next command is taken at the edge that ends the result beat, so such a
// command is finished before the next one is taken.
// An append runs two such multipliers side by side (hash and power); a query uses one
// and fetches the right-hand prefix hash while it works.
// Reset. The string length returns to zero. Entry zero of both stores is never written;
// it reads as hash zero and power one, so the stores need no clearing pass.
module substring_rolling_hash #(
   parameter int unsigned MAX_LEN = srh_pkg::DEFAULT_MAX_LEN
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [srh_pkg::KIND_W-1:0]    req_kind,
   input  logic [srh_pkg::BYTE_W-1:0]    req_char_byte,
   input  logic [srh_pkg::POS_W-1:0]     req_left,
   input  logic [srh_pkg::POS_W-1:0]     req_right,
   output logic                          rsp_valid,
   output logic [srh_pkg::HASH_W-1:0]    rsp_hash_value,
   output logic [srh_pkg::STATUS_W-1:0]  rsp_status
);
   import srh_pkg::*;

   localparam int DEPTH = MAX_LEN + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = (AW > POS_W) ? AW : POS_W;

   // Stores: one entry per prefix length.
   logic [HASH_W-1:0] prefix_mem [0:DEPTH-1];
   logic [HASH_W-1:0] power_mem  [0:DEPTH-1];

   srh_state_type      state_ff, state_in;
   logic [AW-1:0]      len_ff, len_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0]  rsp_hash_ff, rsp_hash_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [KIND_W-1:0]  kind_ff;
   logic [BYTE_W-1:0]  byte_ff;
   logic [POS_W-1:0]   right_ff;

   logic [HASH_W-1:0]  prefix_rd_ff, power_rd_ff;
   logic               prefix_zero_ff, power_zero_ff;

   logic               accept, full, bad_range, req_load;
   logic               prefix_re, power_re, store_we;
   logic [AW-1:0]      prefix_ra, power_ra, wr_addr;
   logic [HASH_W-1:0]  prefix_wd, power_wd;
   logic [HASH_W-1:0]  prefix_val, power_val;
   logic               mul_start, mul0_done, mul1_done;
   logic [HASH_W-1:0]  mul0_b, mul0_res, mul1_res;
   logic [HASH_W:0]    app_sum, qry_sum;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign full      = (len_ff >= AW'(MAX_LEN));
   assign bad_range = (req_left > req_right) || (CW'(req_right) > CW'(len_ff));
   assign wr_addr   = len_ff + AW'(1);

   // Entry zero is never written; its reset contents are supplied here.
   assign prefix_val = prefix_zero_ff ? '0 : prefix_rd_ff;
   assign power_val  = power_zero_ff ? HASH_W'(1) : power_rd_ff;

   // New prefix hash: product plus byte plus one, folded once.
   assign app_sum   = {1'b0, mul0_res} + (HASH_W + 1)'(byte_ff) + (HASH_W + 1)'(1);
   assign prefix_wd = (app_sum >= {1'b0, HASH_MOD}) ? HASH_W'(app_sum - {1'b0, HASH_MOD})
                                                    : app_sum[HASH_W-1:0];
   assign power_wd  = mul1_res;

   // Query: H[right] + p - H[left]*P[right-left], folded once.
   assign qry_sum = {1'b0, prefix_val} + {1'b0, HASH_MOD} - {1'b0, mul0_res};

   assign mul0_b = (kind_ff == KIND_APPEND) ? HASH_BASE : power_val;

   srh_mod_mul u_mul_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (prefix_val),
      .b      (mul0_b),
      .done   (mul0_done),
      .result (mul0_res)
   );

   srh_mod_mul u_mul_power (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (power_val),
      .b      (HASH_BASE),
      .done   (mul1_done),
      .result (mul1_res)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_APPEND: state_in = full ? ST_IDLE : ST_READ;
                  KIND_QUERY:  state_in = bad_range ? ST_IDLE : ST_READ;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: state_in = ST_MUL;
         ST_MUL: begin
            if (mul0_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: store accesses, multiplier start and the result beat.
   always_comb begin
      req_load      = 1'b0;
      prefix_re     = 1'b0;
      power_re      = 1'b0;
      prefix_ra     = len_ff;
      power_ra      = len_ff;
      store_we      = 1'b0;
      mul_start     = 1'b0;
      len_in        = len_ff;
      rsp_valid_in  = 1'b0;
      rsp_hash_in   = '0;
      rsp_status_in = STATUS_OK;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_load = 1'b1;
               case (req_kind)
                  KIND_APPEND: begin
                     if (full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        prefix_re = 1'b1;
                        power_re  = 1'b1;
                     end
                  end
                  KIND_QUERY: begin
                     if (bad_range) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_BAD_RANGE;
                     end else begin
                        prefix_re = 1'b1;
                        power_re  = 1'b1;
                        prefix_ra = AW'(req_left);
                        power_ra  = AW'(req_right - req_left);
                     end
                  end
                  KIND_CLEAR: begin
                     len_in       = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            mul_start = 1'b1;
            // A query fetches H[right] while the multiply runs.
            if (kind_ff == KIND_QUERY) begin
               prefix_re = 1'b1;
               prefix_ra = AW'(right_ff);
            end
         end
         ST_MUL: begin
            if (mul0_done) begin
               rsp_valid_in = 1'b1;
               if (kind_ff == KIND_APPEND) begin
                  store_we = 1'b1;
                  len_in   = wr_addr;
               end else begin
                  rsp_hash_in = (qry_sum >= {1'b0, HASH_MOD})
                              ? HASH_W'(qry_sum - {1'b0, HASH_MOD})
                              : qry_sum[HASH_W-1:0];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hash_ff   <= rsp_hash_in;
      rsp_status_ff <= rsp_status_in;
      if (req_load) begin
         kind_ff  <= req_kind;
         byte_ff  <= req_char_byte;
         right_ff <= req_right;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         prefix_mem[wr_addr] <= prefix_wd;
      end
      if (prefix_re) begin
         prefix_rd_ff   <= prefix_mem[prefix_ra];
         prefix_zero_ff <= (prefix_ra == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         power_mem[wr_addr] <= power_wd;
      end
      if (power_re) begin
         power_rd_ff   <= power_mem[power_ra];
         power_zero_ff <= (power_ra == '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;
   assign rsp_status     = rsp_status_ff;

   // The string never grows past the store.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= AW'(MAX_LEN))
      else $error("string length beyond store depth");

   // An append on a full store is answered at once with the full status.
   a_full_answer: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_APPEND && full)
      |=> (rsp_valid && rsp_status == STATUS_FULL && len_ff == $past(len_ff)))
      else $error("full append not answered or length changed");

   // The multipliers finish together and only while the sequencer waits for them.
   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      (mul0_done || mul1_done) |-> (mul0_done && mul1_done && state_ff == ST_MUL))
      else $error("multiplier done out of step with the sequencer");

   // A beat with a non-ok status carries a zero hash.
   a_zero_hash: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_hash_value == '0))
      else $error("non-zero hash on a flagged beat");

endmodule

// ===== sim/substring_rolling_hash_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the substring rolling hash block.
module substring_rolling_hash_tb;
   import srh_pkg::*;

   // The string store holds up to MAX_LEN bytes; the block runs at its default size.
   localparam int unsigned MAX_LEN = DEFAULT_MAX_LEN;
   localparam int SUM_W = HASH_W + 1;
   localparam int unsigned POS_MAX = (1 << POS_W) - 1;

   // The fourth command code has no function; the block must answer it with a plain
   // OK beat and leave its state alone.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // Run limits. The slowest correct run is far shorter than the watchdog limit, so the
   // watchdog leaves a wide margin. The drain covers one full multiply.
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned RANDOM_BEATS = 1850;
   localparam int unsigned IDLE_PERCENT = 36;

   typedef struct packed {
      logic [HASH_W-1:0]   hash_value;
      logic [STATUS_W-1:0] status;
   } hash_result_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [KIND_W-1:0]   req_kind;
   logic [BYTE_W-1:0]   req_char_byte;
   logic [POS_W-1:0]    req_left;
   logic [POS_W-1:0]    req_right;
   logic                rsp_valid;
   logic [HASH_W-1:0]   rsp_hash_value;
   logic [STATUS_W-1:0] rsp_status;

   // Our own copy of the string state: prefix hashes, base powers and the length.
   logic [HASH_W-1:0] prefix_model [0:MAX_LEN];
   logic [HASH_W-1:0] power_model [0:MAX_LEN];
   int unsigned       length_model;

   // Result beats that have been predicted but not yet seen, oldest first.
   hash_result_type pending_hashes [$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned idle_percent;

   substring_rolling_hash #(
      .MAX_LEN(MAX_LEN)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_char_byte  (req_char_byte),
      .req_left       (req_left),
      .req_right      (req_right),
      .rsp_valid      (rsp_valid),
      .rsp_hash_value (rsp_hash_value),
      .rsp_status     (rsp_status)
   );

   always #6 clock = ~clock;

   // Product of two residues modulo 2^61-1. The full 122-bit product is folded once:
   // the bits from position 61 up weigh exactly one, since 2^61 is congruent to one.
   // Neither half exceeds the modulus, so one conditional subtraction finishes it.
   function automatic logic [HASH_W-1:0] mersenne_mul(input logic [HASH_W-1:0] a,
                                                      input logic [HASH_W-1:0] b);
      logic [PROD_W-1:0] product;
      logic [SUM_W-1:0]  folded;
      product = PROD_W'(a) * PROD_W'(b);
      folded = SUM_W'(product[PROD_W-1:HASH_W]) + SUM_W'(product[HASH_W-1:0]);
      if (folded >= SUM_W'(HASH_MOD)) begin
         folded = folded - SUM_W'(HASH_MOD);
      end
      return folded[HASH_W-1:0];
   endfunction

   // Applies one accepted command beat to our copy of the state and queues the result
   // beat that the block must give for it.
   task automatic predict_hash_beat(input logic [KIND_W-1:0] kind,
                                    input logic [BYTE_W-1:0] char_byte,
                                    input logic [POS_W-1:0]  left,
                                    input logic [POS_W-1:0]  right);
      hash_result_type   expected;
      logic [SUM_W-1:0]  sum;
      logic [HASH_W-1:0] shifted_left;
      expected.hash_value = '0;
      expected.status = STATUS_OK;
      case (kind)
         KIND_APPEND: begin
            // A full store drops the byte and leaves the string as it is.
            if (length_model >= MAX_LEN) begin
               expected.status = STATUS_FULL;
            end else begin
               power_model[length_model + 1] = mersenne_mul(power_model[length_model],
                                                            HASH_BASE);
               // The byte is offset by one so that a zero byte still changes the hash.
               sum = SUM_W'(mersenne_mul(prefix_model[length_model], HASH_BASE))
                     + SUM_W'(char_byte) + SUM_W'(1);
               if (sum >= SUM_W'(HASH_MOD)) begin
                  sum = sum - SUM_W'(HASH_MOD);
               end
               prefix_model[length_model + 1] = sum[HASH_W-1:0];
               length_model++;
            end
         end
         KIND_QUERY: begin
            // Only positions up to the current length have been written, so a range
            // outside them is refused before any store is read.
            if (left > right || right > length_model) begin
               expected.status = STATUS_BAD_RANGE;
            end else begin
               shifted_left = mersenne_mul(prefix_model[left], power_model[right - left]);
               sum = SUM_W'(prefix_model[right]) + SUM_W'(HASH_MOD) - SUM_W'(shifted_left);
               if (sum >= SUM_W'(HASH_MOD)) begin
                  sum = sum - SUM_W'(HASH_MOD);
               end
               expected.hash_value = sum[HASH_W-1:0];
            end
         end
         KIND_CLEAR: begin
            length_model = 0;
         end
         default: begin
         end
      endcase
      pending_hashes.push_back(expected);
   endtask

   // Sends one command beat. Inputs change on the falling edge; the beat is taken at
   // the first rising edge with busy low. A random idle gap with start low may
   // come first, so start rises at every phase of the block's multiply. Start
   // stays high from one beat to the next when there is no gap.
   task automatic send_beat(input logic [KIND_W-1:0] kind,
                            input logic [BYTE_W-1:0] char_byte,
                            input logic [POS_W-1:0]  left,
                            input logic [POS_W-1:0]  right);
      if ($urandom_range(99) < idle_percent) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(9)) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_kind <= kind;
      req_char_byte <= char_byte;
      req_left <= left;
      req_right <= right;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_hash_beat(kind, char_byte, left, right);
   endtask

   // A query with random content: either a range inside the current string, or one
   // that is broken by reaching past the end or by running backwards.
   task automatic send_random_query(input bit in_range);
      logic [POS_W-1:0] left;
      logic [POS_W-1:0] right;
      if (in_range) begin
         right = POS_W'($urandom_range(length_model, 0));
         left = POS_W'($urandom_range(right, 0));
      end else if (length_model < MAX_LEN && $urandom_range(1) == 1) begin
         right = POS_W'($urandom_range(POS_MAX, length_model + 1));
         left = POS_W'($urandom_range(POS_MAX, 0));
      end else begin
         right = POS_W'($urandom_range(POS_MAX - 1, 0));
         left = POS_W'($urandom_range(POS_MAX, right + 1));
      end
      send_beat(KIND_QUERY, BYTE_W'($urandom), left, right);
   endtask

   // The empty string straight after reset: only the empty range at zero is valid.
   task automatic test_empty_string();
      send_beat(KIND_QUERY, 8'h00, 12'd0, 12'd0);
      send_beat(KIND_QUERY, 8'h00, 12'd0, 12'd1);
      send_beat(KIND_QUERY, 8'hFF, POS_W'(POS_MAX), POS_W'(POS_MAX));
      send_beat(KIND_UNUSED, 8'hFF, POS_W'(POS_MAX), POS_W'(POS_MAX));
      send_beat(KIND_CLEAR, 8'h00, 12'd0, 12'd0);
   endtask

   // Extreme bytes, full, single and empty ranges, both kinds of bad range, and a
   // clear followed by a fresh string.
   task automatic test_directed_beats();
      send_beat(KIND_APPEND, 8'h00, 12'd0, 12'd0);
      send_beat(KIND_APPEND, 8'hFF, POS_W'(POS_MAX), POS_W'(POS_MAX));
      send_beat(KIND_APPEND, 8'hAA, 12'hAAA, 12'h555);
      send_beat(KIND_APPEND, 8'h55, 12'h555, 12'hAAA);
      send_beat(KIND_QUERY, 8'h00, 12'd0, 12'd4);
      send_beat(KIND_QUERY, 8'h00, 12'd0, 12'd1);
      send_beat(KIND_QUERY, 8'h00, 12'd3, 12'd4);
      send_beat(KIND_QUERY, 8'h00, 12'd2, 12'd2);
      send_beat(KIND_QUERY, 8'h00, 12'd4, 12'd4);
      send_beat(KIND_QUERY, 8'h00, 12'd2, 12'd1);
      send_beat(KIND_QUERY, 8'h00, 12'd0, 12'd5);
      send_beat(KIND_QUERY, 8'h00, POS_W'(POS_MAX), 12'd0);
      send_beat(KIND_UNUSED, 8'h00, 12'd0, 12'd0);
      send_beat(KIND_QUERY, 8'h00, 12'd1, 12'd3);
      send_beat(KIND_CLEAR, 8'hFF, POS_W'(POS_MAX), POS_W'(POS_MAX));
      send_beat(KIND_QUERY, 8'h00, 12'd0, 12'd1);
      send_beat(KIND_QUERY, 8'h00, 12'd0, 12'd0);
      send_beat(KIND_APPEND, 8'h80, 12'd0, 12'd0);
      send_beat(KIND_QUERY, 8'h00, 12'd0, 12'd1);
   endtask

   // Mostly appends and in-range queries, so the string grows well beyond a few bytes
   // between clears; broken queries, clears and the unused code make up the rest.
   // Fields that a command does not use carry random values all the same. A stretch
   // in the middle runs without any idle cycle.
   task automatic test_random_beats();
      int unsigned pick;
      for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
         idle_percent = (n >= 600 && n < 900) ? 0 : IDLE_PERCENT;
         pick = $urandom_range(99);
         if (pick < 48) begin
            send_beat(KIND_APPEND, BYTE_W'($urandom), POS_W'($urandom), POS_W'($urandom));
         end else if (pick < 80) begin
            send_random_query(1'b1);
         end else if (pick < 90) begin
            send_random_query(1'b0);
         end else if (pick < 93) begin
            send_beat(KIND_CLEAR, BYTE_W'($urandom), POS_W'($urandom), POS_W'($urandom));
         end else begin
            send_beat(KIND_UNUSED, BYTE_W'($urandom), POS_W'($urandom), POS_W'($urandom));
         end
      end
      idle_percent = IDLE_PERCENT;
   endtask

   // Every result beat is matched against the oldest prediction. An unknown strobe is
   // treated as a beat, so that it cannot slip past unnoticed.
   always @(posedge clock) begin : hash_checker
      hash_result_type expected;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_hashes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("%0t: result beat with nothing pending: hash %0h status %0d",
                        $realtime, rsp_hash_value, rsp_status);
            end
         end else begin
            expected = pending_hashes.pop_front();
            if (rsp_hash_value !== expected.hash_value || rsp_status !== expected.status) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: hash expected %0h got %0h, status expected %0d got %0d",
                           $realtime, expected.hash_value, rsp_hash_value,
                           expected.status, rsp_status);
               end
            end
         end
      end
   end

   always @(posedge clock) begin : run_watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : test_sequence
      reset = 1'b1;
      start = 1'b0;
      req_kind = KIND_APPEND;
      req_char_byte = '0;
      req_left = '0;
      req_right = '0;
      idle_percent = IDLE_PERCENT;
      length_model = 0;
      prefix_model[0] = '0;
      power_model[0] = HASH_W'(1);
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_empty_string();
      test_directed_beats();
      test_random_beats();

      // Stop sending, let the last beats come back, then give the block time to show
      // any stray beat it might still produce.
      @(negedge clock);
      start <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
